// ===== rtl/core/fms_pkg.sv =====
// Shared types, codes and lookup functions of the flight mode sequencer.
// No dependencies; every other file uses this package by scoped names.
package fms_pkg;

    localparam int unsigned BrakeTicksW = 16;
    localparam logic [BrakeTicksW-1:0] BrakeTicksReset = 16'd200;

    typedef enum logic [1:0] {
        REQ_RC     = 2'd0,
        REQ_TICK   = 2'd1,
        REQ_GROUND = 2'd2,
        REQ_UNUSED = 2'd3
    } req_kind_t;

    localparam logic [7:0] CMD_MOTOR_OFF = 8'd1;
    localparam logic [7:0] CMD_MOTOR_ON  = 8'd2;

    localparam logic signed [9:0] ZoneB0 = -10'sd350;
    localparam logic signed [9:0] ZoneB1 = -10'sd150;
    localparam logic signed [9:0] ZoneB2 = 10'sd0;
    localparam logic signed [9:0] ZoneB3 = 10'sd150;
    localparam logic signed [9:0] ZoneB4 = 10'sd350;

    localparam logic [3:0] MODE_MANUAL      = 4'd0;
    localparam logic [3:0] MODE_ROLL_AUTO   = 4'd1;
    localparam logic [3:0] MODE_HOLD        = 4'd2;
    localparam logic [3:0] MODE_ROLL_FLOW   = 4'd3;
    localparam logic [3:0] MODE_FULL_FLOW   = 4'd4;
    localparam logic [3:0] MODE_FORWARD     = 4'd5;
    localparam logic [3:0] MODE_BACK        = 4'd6;
    localparam logic [3:0] MODE_BRAKE_FWD   = 4'd7;
    localparam logic [3:0] MODE_BRAKE_BACK  = 4'd8;

    localparam logic [3:0] PCMD_NONE     = 4'd0;
    localparam logic [3:0] PCMD_MANUAL   = 4'd1;
    localparam logic [3:0] PCMD_ROLL     = 4'd2;
    localparam logic [3:0] PCMD_FLOW     = 4'd3;
    localparam logic [3:0] PCMD_FORWARD  = 4'd4;
    localparam logic [3:0] PCMD_HOLD     = 4'd5;
    localparam logic [3:0] PCMD_BACK     = 4'd6;
    localparam logic [3:0] PCMD_BRAKE_F  = 4'd7;
    localparam logic [3:0] PCMD_BRAKE_B  = 4'd8;

    localparam logic [2:0] HMODE_MANUAL = 3'd0;
    localparam logic [2:0] HMODE_HOLD   = 3'd1;
    localparam logic [2:0] HMODE_LAND   = 3'd4;

    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [9:0] aux2_level;
        logic signed [9:0] aux3_level;
        logic signed [9:0] aux4_level;
        logic              auto_enabled;
        logic [7:0]        out_cmd;
    } req_t;

    typedef struct packed {
        logic [3:0] pitch_rate;
        logic       pitch_pos;
        logic [2:0] roll_rate;
        logic       roll_pos;
    } sel_t;

    typedef struct packed {
        logic [2:0] alt_mode;
        logic [3:0] nav_mode;
        sel_t       sel;
        logic       motor_enable;
    } rsp_t;

    function automatic sel_t loop_sel(input logic [3:0] mode, input sel_t keep);
        sel_t s;
        s = keep;
        case (mode)
            MODE_MANUAL:     s = '{4'd0, 1'b0, 3'd0, 1'b0};
            MODE_ROLL_AUTO:  s = '{4'd0, 1'b0, 3'd1, 1'b1};
            MODE_HOLD:       s = '{4'd1, 1'b1, 3'd1, 1'b1};
            MODE_ROLL_FLOW:  s = '{4'd0, 1'b0, 3'd4, 1'b1};
            MODE_FULL_FLOW:  s = '{4'd4, 1'b1, 3'd4, 1'b1};
            MODE_FORWARD:    s = '{4'd2, 1'b0, 3'd1, 1'b1};
            MODE_BACK:       s = '{4'd3, 1'b0, 3'd1, 1'b1};
            MODE_BRAKE_FWD:  s = '{4'd7, 1'b0, 3'd1, 1'b1};
            MODE_BRAKE_BACK: s = '{4'd8, 1'b0, 3'd1, 1'b1};
            default:         s = keep;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] zone_of(input logic signed [9:0] a);
        logic [2:0] z;
        if (a < ZoneB0)
            z = 3'd0;
        else if (a < ZoneB1)
            z = 3'd1;
        else if (a < ZoneB2)
            z = 3'd2;
        else if (a < ZoneB3)
            z = 3'd3;
        else if (a < ZoneB4)
            z = 3'd4;
        else
            z = 3'd5;
        return z;
    endfunction

endpackage

// ===== rtl/core/flight_mode_sequencer.sv =====
// Top level of the flight mode sequencer: input register, mode state and
// result register. Depends on fms_pkg, fms_in_stage, fms_core, fms_out_stage.
//
//  channel   handshake              payload
//  request   req_valid / req_stall  req_type, aux2/3/4_level, auto_enabled, out_cmd
//  result    rsp_valid / rsp_stall  alt_mode, nav_mode, loop selects, motor_enable
//  config    cfg_valid / cfg_ready  cfg_data (brake_ticks)
//
// One request per cycle while the result side does not stall; a taken request passes
// through the input register and the mode logic into the result register.
// Reset clears all mode state and sets brake_ticks to 200; cfg_ready is always high.
// A stalled result holds; the input register then fills and req_stall rises.
module flight_mode_sequencer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [1:0]                      req_type,
    input  logic signed [9:0]               aux2_level,
    input  logic signed [9:0]               aux3_level,
    input  logic signed [9:0]               aux4_level,
    input  logic                            auto_enabled,
    input  logic [7:0]                      out_cmd,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [2:0]                      alt_mode,
    output logic [3:0]                      nav_mode,
    output logic                            roll_pos_sel,
    output logic [2:0]                      roll_rate_sel,
    output logic                            pitch_pos_sel,
    output logic [3:0]                      pitch_rate_sel,
    output logic                            yaw_sel,
    output logic                            motor_enable,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fms_pkg::BrakeTicksW-1:0] cfg_data
);

    fms_pkg::req_t req_in;
    fms_pkg::req_t stage_req;
    fms_pkg::rsp_t rsp_next;
    fms_pkg::rsp_t rsp_out;
    logic          out_ready;
    logic          advance;

    assign req_in    = '{req_type, aux2_level, aux3_level, aux4_level, auto_enabled, out_cmd};
    assign cfg_ready = 1'b1;

    fms_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_in    (req_in),
        .out_ready (out_ready),
        .advance   (advance),
        .stage_req (stage_req)
    );

    fms_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .step_en   (advance),
        .req       (stage_req),
        .rsp_next  (rsp_next)
    );

    fms_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .rsp_in    (rsp_next),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .out_ready (out_ready),
        .rsp_out   (rsp_out)
    );

    assign alt_mode       = rsp_out.alt_mode;
    assign nav_mode       = rsp_out.nav_mode;
    assign roll_pos_sel   = rsp_out.sel.roll_pos;
    assign roll_rate_sel  = rsp_out.sel.roll_rate;
    assign pitch_pos_sel  = rsp_out.sel.pitch_pos;
    assign pitch_rate_sel = rsp_out.sel.pitch_rate;
    assign yaw_sel        = 1'b0;
    assign motor_enable   = rsp_out.motor_enable;

endmodule

// ===== rtl/core/fms_in_stage.sv =====
// Input register of the flight mode sequencer: holds one request and
// releases it when the result register can take it. Uses fms_pkg.
module fms_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  fms_pkg::req_t req_in,
    input  logic          out_ready,
    output logic          advance,
    output fms_pkg::req_t stage_req
);

    logic          valid_reg;
    logic          valid_next;
    fms_pkg::req_t req_reg;
    logic          take;

    assign req_stall  = valid_reg && !out_ready;
    assign advance    = valid_reg && out_ready;
    assign take       = req_valid && !req_stall;
    assign valid_next = take || (valid_reg && !advance);
    assign stage_req  = req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            req_reg <= req_in;
    end

endmodule

// ===== rtl/core/fms_core.sv =====
// Mode state of the flight mode sequencer: zone and switch decoding, the
// pending command, braking counter and loop selections. Uses fms_pkg.
module fms_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fms_pkg::BrakeTicksW-1:0]  cfg_data,
    input  logic                             step_en,
    input  fms_pkg::req_t                    req,
    output fms_pkg::rsp_t                    rsp_next
);

    logic [fms_pkg::BrakeTicksW-1:0] brake_ticks_reg;
    logic [2:0]                      prev_zone_reg, prev_zone_next;
    logic [3:0]                      pending_reg, pending_next;
    logic [1:0]                      hsel_reg, hsel_next;
    logic [fms_pkg::BrakeTicksW-1:0] brake_count_reg, brake_count_next;
    logic [3:0]                      mode_now_reg, mode_now_next;
    logic [3:0]                      mode_before_reg, mode_before_next;
    logic [2:0]                      hmode_reg, hmode_next;
    fms_pkg::sel_t                   sel_reg, sel_next;
    logic                            motor_on_reg, motor_on_next;
    logic                            stop_seen_reg, stop_seen_next;
    logic                            run_seen_reg, run_seen_next;

    logic [2:0]                      zone;
    logic [3:0]                      cmd;
    logic [fms_pkg::BrakeTicksW:0]   count_inc;

    assign zone = fms_pkg::zone_of(req.aux2_level);

    always_comb
    begin
        prev_zone_next   = prev_zone_reg;
        pending_next     = pending_reg;
        hsel_next        = hsel_reg;
        brake_count_next = brake_count_reg;
        mode_now_next    = mode_now_reg;
        mode_before_next = mode_before_reg;
        hmode_next       = hmode_reg;
        sel_next         = sel_reg;
        motor_on_next    = motor_on_reg;
        stop_seen_next   = stop_seen_reg;
        run_seen_next    = run_seen_reg;
        cmd              = pending_reg;
        count_inc        = '0;

        if (step_en)
        begin
            case (fms_pkg::req_kind_t'(req.req_type))
                fms_pkg::REQ_RC:
                begin
                    if (zone != prev_zone_reg)
                        pending_next = {1'b0, zone} + 4'd1;
                    prev_zone_next = zone;

                    if (req.aux3_level < fms_pkg::ZoneB1)
                        hsel_next = 2'd0;
                    else if (req.aux3_level < fms_pkg::ZoneB3)
                        hsel_next = 2'd1;
                    else
                        hsel_next = 2'd2;

                    if (req.aux4_level > 10'sd0)
                    begin
                        run_seen_next = 1'b0;
                        if (!stop_seen_reg)
                        begin
                            stop_seen_next = 1'b1;
                            motor_on_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        stop_seen_next = 1'b0;
                        if (!run_seen_reg)
                        begin
                            run_seen_next = 1'b1;
                            motor_on_next = 1'b1;
                        end
                    end
                end
                fms_pkg::REQ_TICK:
                begin
                    if (req.auto_enabled)
                    begin
                        case (hsel_reg)
                            2'd1:    hmode_next = fms_pkg::HMODE_HOLD;
                            2'd2:    hmode_next = fms_pkg::HMODE_LAND;
                            default: hmode_next = fms_pkg::HMODE_MANUAL;
                        endcase

                        if (cmd != fms_pkg::PCMD_NONE)
                        begin
                            case (cmd)
                                fms_pkg::PCMD_MANUAL:  mode_now_next = fms_pkg::MODE_MANUAL;
                                fms_pkg::PCMD_ROLL:    mode_now_next = fms_pkg::MODE_ROLL_AUTO;
                                fms_pkg::PCMD_FLOW:    mode_now_next = fms_pkg::MODE_ROLL_FLOW;
                                fms_pkg::PCMD_FORWARD: mode_now_next = fms_pkg::MODE_FORWARD;
                                fms_pkg::PCMD_HOLD:
                                begin
                                    if (mode_before_reg == fms_pkg::MODE_FORWARD)
                                    begin
                                        cmd              = fms_pkg::PCMD_BRAKE_F;
                                        brake_count_next = '0;
                                    end
                                    else if (mode_before_reg == fms_pkg::MODE_BACK)
                                    begin
                                        cmd              = fms_pkg::PCMD_BRAKE_B;
                                        brake_count_next = '0;
                                    end
                                    else
                                        mode_now_next = fms_pkg::MODE_HOLD;
                                end
                                fms_pkg::PCMD_BACK:    mode_now_next = fms_pkg::MODE_BACK;
                                default:               mode_now_next = mode_now_reg;
                            endcase

                            if (cmd == fms_pkg::PCMD_BRAKE_F || cmd == fms_pkg::PCMD_BRAKE_B)
                            begin
                                count_inc     = {1'b0, brake_count_next} + 1'b1;
                                mode_now_next = cmd;
                                if (count_inc > {1'b0, brake_ticks_reg})
                                begin
                                    brake_count_next = '0;
                                    pending_next     = fms_pkg::PCMD_NONE;
                                    mode_now_next    = fms_pkg::MODE_HOLD;
                                end
                                else
                                begin
                                    brake_count_next = count_inc[fms_pkg::BrakeTicksW-1:0];
                                    pending_next     = cmd;
                                end
                            end
                            else if (cmd <= fms_pkg::PCMD_BACK)
                                pending_next = fms_pkg::PCMD_NONE;
                            else
                                pending_next = cmd;
                        end

                        sel_next         = fms_pkg::loop_sel(mode_now_next, sel_reg);
                        mode_before_next = mode_now_next;
                    end
                end
                fms_pkg::REQ_GROUND:
                begin
                    if (req.out_cmd == fms_pkg::CMD_MOTOR_OFF)
                        motor_on_next = 1'b0;
                    else if (req.out_cmd == fms_pkg::CMD_MOTOR_ON)
                        motor_on_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rsp_next = '{hmode_next, mode_now_next, sel_next, motor_on_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_ticks_reg <= fms_pkg::BrakeTicksReset;
            prev_zone_reg   <= '0;
            pending_reg     <= '0;
            hsel_reg        <= '0;
            brake_count_reg <= '0;
            mode_now_reg    <= '0;
            mode_before_reg <= '0;
            hmode_reg       <= '0;
            sel_reg         <= '0;
            motor_on_reg    <= 1'b0;
            stop_seen_reg   <= 1'b0;
            run_seen_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                brake_ticks_reg <= cfg_data;
            prev_zone_reg   <= prev_zone_next;
            pending_reg     <= pending_next;
            hsel_reg        <= hsel_next;
            brake_count_reg <= brake_count_next;
            mode_now_reg    <= mode_now_next;
            mode_before_reg <= mode_before_next;
            hmode_reg       <= hmode_next;
            sel_reg         <= sel_next;
            motor_on_reg    <= motor_on_next;
            stop_seen_reg   <= stop_seen_next;
            run_seen_reg    <= run_seen_next;
        end
    end

    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        mode_now_reg <= fms_pkg::MODE_BRAKE_BACK)
        else $error("flight mode out of range");

    a_pending_range: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= fms_pkg::PCMD_BRAKE_B)
        else $error("pending command out of range");

    a_mode_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        mode_before_reg == mode_now_reg)
        else $error("previous mode lost track of current mode");

    a_switch_edges: assert property (@(posedge clk) disable iff (!rst_n)
        !(stop_seen_reg && run_seen_reg))
        else $error("motor switch seen in both positions");

    a_no_tick_no_mode: assert property (@(posedge clk) disable iff (!rst_n)
        !(step_en && req.req_type == fms_pkg::REQ_TICK && req.auto_enabled)
        |=> $stable(mode_now_reg))
        else $error("flight mode changed without a mode tick");

endmodule

// ===== rtl/core/fms_out_stage.sv =====
// Result register of the flight mode sequencer: holds one result until the
// downstream side takes it. Uses fms_pkg.
module fms_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  fms_pkg::rsp_t rsp_in,
    input  logic          rsp_stall,
    output logic          rsp_valid,
    output logic          out_ready,
    output fms_pkg::rsp_t rsp_out
);

    logic          valid_reg;
    logic          valid_next;
    fms_pkg::rsp_t rsp_reg;

    assign out_ready  = !valid_reg || !rsp_stall;
    assign valid_next = load || (valid_reg && rsp_stall);
    assign rsp_valid  = valid_reg;
    assign rsp_out    = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rsp_reg <= rsp_in;
    end

endmodule

// ===== dv/flight_mode_sequencer_tb.sv =====
// Testbench for flight_mode_sequencer: directed and random requests, a built-in
// mode predictor and a field-by-field check of every result, over several brake_ticks
// settings. Depends on fms_pkg and the flight_mode_sequencer RTL.
module flight_mode_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] RS_CAMERA  = 3'd1;
    localparam logic [2:0] RS_FLOW    = 3'd4;
    localparam logic [3:0] PS_HOLD    = 4'd1;
    localparam logic [3:0] PS_FORWARD = 4'd2;
    localparam logic [3:0] PS_BACK    = 4'd3;
    localparam logic [3:0] PS_FLOW    = 4'd4;
    localparam logic [3:0] PS_BRAKE_F = 4'd7;
    localparam logic [3:0] PS_BRAKE_B = 4'd8;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic [1:0]        req_type = fms_pkg::REQ_RC;
    logic signed [9:0] aux2_level = '0;
    logic signed [9:0] aux3_level = '0;
    logic signed [9:0] aux4_level = '0;
    logic              auto_enabled = 1'b0;
    logic [7:0]        out_cmd = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    logic [2:0]        alt_mode;
    logic [3:0]        nav_mode;
    logic              roll_pos_sel;
    logic [2:0]        roll_rate_sel;
    logic              pitch_pos_sel;
    logic [3:0]        pitch_rate_sel;
    logic              yaw_sel;
    logic              motor_enable;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [15:0]       cfg_data = '0;

    flight_mode_sequencer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .aux2_level     (aux2_level),
        .aux3_level     (aux3_level),
        .aux4_level     (aux4_level),
        .auto_enabled   (auto_enabled),
        .out_cmd        (out_cmd),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .alt_mode       (alt_mode),
        .nav_mode       (nav_mode),
        .roll_pos_sel   (roll_pos_sel),
        .roll_rate_sel  (roll_rate_sel),
        .pitch_pos_sel  (pitch_pos_sel),
        .pitch_rate_sel (pitch_rate_sel),
        .yaw_sel        (yaw_sel),
        .motor_enable   (motor_enable),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // predictor state
    logic [15:0]   brake_limit = fms_pkg::BrakeTicksReset;
    logic [2:0]    last_zone = '0;
    logic [3:0]    queued_cmd = fms_pkg::PCMD_NONE;
    logic [1:0]    height_pick = '0;
    logic [15:0]   brake_cnt = '0;
    logic [3:0]    cur_mode = fms_pkg::MODE_MANUAL;
    logic [3:0]    prev_mode = fms_pkg::MODE_MANUAL;
    logic [2:0]    height_out = fms_pkg::HMODE_MANUAL;
    fms_pkg::sel_t loop_pick = '0;
    logic          motor_on = 1'b0;
    logic          stop_latched = 1'b0;
    logic          run_latched = 1'b0;

    fms_pkg::req_t request_queue[$];
    fms_pkg::rsp_t expected_outputs[$];
    fms_pkg::req_t in_flight;
    fms_pkg::rsp_t seen_rsp;
    fms_pkg::rsp_t want_rsp;
    int            send_gap = 0;
    int            stall_left = 0;
    int            mismatch_count = 0;
    bit            quiet = 1'b0;

    function automatic fms_pkg::rsp_t apply_request(input fms_pkg::req_t r);
        logic [2:0]    zone;
        logic [3:0]    c;
        logic [16:0]   nxt;
        fms_pkg::rsp_t o;
        case (r.req_type)
            fms_pkg::REQ_RC:
            begin
                if (r.aux2_level < fms_pkg::ZoneB0)
                    zone = 3'd0;
                else if (r.aux2_level < fms_pkg::ZoneB1)
                    zone = 3'd1;
                else if (r.aux2_level < fms_pkg::ZoneB2)
                    zone = 3'd2;
                else if (r.aux2_level < fms_pkg::ZoneB3)
                    zone = 3'd3;
                else if (r.aux2_level < fms_pkg::ZoneB4)
                    zone = 3'd4;
                else
                    zone = 3'd5;
                if (zone != last_zone)
                    queued_cmd = {1'b0, zone} + 4'd1;
                last_zone = zone;
                if (r.aux3_level < fms_pkg::ZoneB1)
                    height_pick = 2'd0;
                else if (r.aux3_level < fms_pkg::ZoneB3)
                    height_pick = 2'd1;
                else
                    height_pick = 2'd2;
                if (r.aux4_level > 10'sd0)
                begin
                    run_latched = 1'b0;
                    if (!stop_latched)
                    begin
                        stop_latched = 1'b1;
                        motor_on = 1'b0;
                    end
                end
                else
                begin
                    stop_latched = 1'b0;
                    if (!run_latched)
                    begin
                        run_latched = 1'b1;
                        motor_on = 1'b1;
                    end
                end
            end
            fms_pkg::REQ_TICK:
            begin
                if (r.auto_enabled)
                begin
                    case (height_pick)
                        2'd1: height_out = fms_pkg::HMODE_HOLD;
                        2'd2: height_out = fms_pkg::HMODE_LAND;
                        default: height_out = fms_pkg::HMODE_MANUAL;
                    endcase
                    c = queued_cmd;
                    if (c != fms_pkg::PCMD_NONE)
                    begin
                        case (c)
                            fms_pkg::PCMD_MANUAL:  cur_mode = fms_pkg::MODE_MANUAL;
                            fms_pkg::PCMD_ROLL:    cur_mode = fms_pkg::MODE_ROLL_AUTO;
                            fms_pkg::PCMD_FLOW:    cur_mode = fms_pkg::MODE_ROLL_FLOW;
                            fms_pkg::PCMD_FORWARD: cur_mode = fms_pkg::MODE_FORWARD;
                            fms_pkg::PCMD_BACK:    cur_mode = fms_pkg::MODE_BACK;
                            fms_pkg::PCMD_HOLD:
                            begin
                                if (prev_mode == fms_pkg::MODE_FORWARD)
                                begin
                                    c = fms_pkg::PCMD_BRAKE_F;
                                    brake_cnt = '0;
                                end
                                else if (prev_mode == fms_pkg::MODE_BACK)
                                begin
                                    c = fms_pkg::PCMD_BRAKE_B;
                                    brake_cnt = '0;
                                end
                                else
                                    cur_mode = fms_pkg::MODE_HOLD;
                            end
                            default: ;
                        endcase
                        queued_cmd = c;
                        if (c == fms_pkg::PCMD_BRAKE_F || c == fms_pkg::PCMD_BRAKE_B)
                        begin
                            cur_mode = (c == fms_pkg::PCMD_BRAKE_F) ?
                                       fms_pkg::MODE_BRAKE_FWD : fms_pkg::MODE_BRAKE_BACK;
                            nxt = {1'b0, brake_cnt} + 17'd1;
                            if (nxt > {1'b0, brake_limit})
                            begin
                                brake_cnt = '0;
                                queued_cmd = fms_pkg::PCMD_NONE;
                                cur_mode = fms_pkg::MODE_HOLD;
                            end
                            else
                                brake_cnt = nxt[15:0];
                        end
                        if (queued_cmd <= fms_pkg::PCMD_BACK)
                            queued_cmd = fms_pkg::PCMD_NONE;
                    end
                    loop_pick = '0;
                    loop_pick.roll_pos = (cur_mode != fms_pkg::MODE_MANUAL);
                    case (cur_mode)
                        fms_pkg::MODE_MANUAL: ;
                        fms_pkg::MODE_ROLL_AUTO:
                            loop_pick.roll_rate = RS_CAMERA;
                        fms_pkg::MODE_HOLD:
                        begin
                            loop_pick.roll_rate = RS_CAMERA;
                            loop_pick.pitch_pos = 1'b1;
                            loop_pick.pitch_rate = PS_HOLD;
                        end
                        fms_pkg::MODE_ROLL_FLOW:
                            loop_pick.roll_rate = RS_FLOW;
                        fms_pkg::MODE_FULL_FLOW:
                        begin
                            loop_pick.roll_rate = RS_FLOW;
                            loop_pick.pitch_pos = 1'b1;
                            loop_pick.pitch_rate = PS_FLOW;
                        end
                        fms_pkg::MODE_FORWARD:
                        begin
                            loop_pick.roll_rate = RS_CAMERA;
                            loop_pick.pitch_rate = PS_FORWARD;
                        end
                        fms_pkg::MODE_BACK:
                        begin
                            loop_pick.roll_rate = RS_CAMERA;
                            loop_pick.pitch_rate = PS_BACK;
                        end
                        fms_pkg::MODE_BRAKE_FWD:
                        begin
                            loop_pick.roll_rate = RS_CAMERA;
                            loop_pick.pitch_rate = PS_BRAKE_F;
                        end
                        fms_pkg::MODE_BRAKE_BACK:
                        begin
                            loop_pick.roll_rate = RS_CAMERA;
                            loop_pick.pitch_rate = PS_BRAKE_B;
                        end
                        default: ;
                    endcase
                    prev_mode = cur_mode;
                end
            end
            fms_pkg::REQ_GROUND:
            begin
                if (r.out_cmd == fms_pkg::CMD_MOTOR_OFF)
                    motor_on = 1'b0;
                else if (r.out_cmd == fms_pkg::CMD_MOTOR_ON)
                    motor_on = 1'b1;
            end
            default: ;
        endcase
        o.alt_mode = height_out;
        o.nav_mode = cur_mode;
        o.sel = loop_pick;
        o.motor_enable = motor_on;
        return o;
    endfunction

    function automatic logic signed [9:0] any_level();
        return 10'($signed($urandom_range(0, 1000)) - 500);
    endfunction

    function automatic fms_pkg::req_t mk_req(input logic [1:0] kind, input int a2,
                                             input int a3, input int a4, input logic on,
                                             input logic [7:0] cmd);
        fms_pkg::req_t r;
        r.req_type = kind;
        r.aux2_level = 10'(a2);
        r.aux3_level = 10'(a3);
        r.aux4_level = 10'(a4);
        r.auto_enabled = on;
        r.out_cmd = cmd;
        return r;
    endfunction

    function automatic fms_pkg::req_t rc_req(input int zone);
        int lo;
        int hi;
        case (zone)
            0: begin lo = -500; hi = -351; end
            1: begin lo = -350; hi = -151; end
            2: begin lo = -150; hi = -1;   end
            3: begin lo = 0;    hi = 149;  end
            4: begin lo = 150;  hi = 349;  end
            default: begin lo = 350; hi = 500; end
        endcase
        return mk_req(fms_pkg::REQ_RC, lo + int'($urandom_range(0, hi - lo)), any_level(),
                      any_level(), 1'($urandom), 8'($urandom));
    endfunction

    function automatic fms_pkg::req_t tick_req(input logic on);
        return mk_req(fms_pkg::REQ_TICK, any_level(), any_level(), any_level(), on,
                      8'($urandom));
    endfunction

    task automatic queue_directed();
        request_queue.push_back(mk_req(fms_pkg::REQ_RC, -500, -500, -500, 1'b0, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_TICK, 0, 0, 0, 1'b1, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_RC, -350, -150, 1, 1'b1, 8'd255));
        request_queue.push_back(mk_req(fms_pkg::REQ_TICK, 0, 0, 0, 1'b0, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_TICK, 0, 0, 0, 1'b1, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_RC, -1, 149, 0, 1'b0, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_TICK, 0, 0, 0, 1'b1, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_RC, 150, 150, 500, 1'b0, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_TICK, 0, 0, 0, 1'b1, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_RC, 0, -151, -1, 1'b0, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_TICK, 0, 0, 0, 1'b1, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_RC, 349, 500, -1, 1'b0, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_TICK, 0, 0, 0, 1'b1, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_TICK, 0, 0, 0, 1'b1, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_RC, 350, 0, -1, 1'b0, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_TICK, 0, 0, 0, 1'b1, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_RC, 200, 0, -1, 1'b0, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_TICK, 0, 0, 0, 1'b1, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_RC, -351, 0, -1, 1'b0, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_TICK, 0, 0, 0, 1'b1, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_GROUND, 0, 0, 0, 1'b0,
                                       fms_pkg::CMD_MOTOR_OFF));
        request_queue.push_back(mk_req(fms_pkg::REQ_GROUND, 0, 0, 0, 1'b0,
                                       fms_pkg::CMD_MOTOR_ON));
        request_queue.push_back(mk_req(fms_pkg::REQ_GROUND, 0, 0, 0, 1'b0, 8'd255));
        request_queue.push_back(mk_req(fms_pkg::REQ_GROUND, 0, 0, 0, 1'b0, 8'd0));
        request_queue.push_back(mk_req(fms_pkg::REQ_UNUSED, -1, -1, -1, 1'b1, 8'd255));
    endtask

    task automatic queue_random(input int target);
        int start;
        int pick;
        int n;
        logic [7:0] cmd;
        start = request_queue.size();
        while (request_queue.size() - start < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                // move, hold, then ride out (or cut short) the brake
                request_queue.push_back(rc_req($urandom_range(0, 1) ? 3 : 5));
                repeat ($urandom_range(1, 2))
                    request_queue.push_back(tick_req(1'b1));
                request_queue.push_back(rc_req(4));
                if (brake_limit < 16'd16)
                    n = $urandom_range(1, int'(brake_limit) + 3);
                else if (pick == 0 && brake_limit <= 16'd300)
                    n = int'(brake_limit) + 2;
                else
                    n = $urandom_range(1, 12);
                repeat (n)
                    request_queue.push_back(tick_req($urandom_range(0, 15) != 0));
            end
            else if (pick < 55)
                request_queue.push_back(rc_req($urandom_range(0, 5)));
            else if (pick < 85)
                request_queue.push_back(tick_req($urandom_range(0, 9) != 0));
            else if (pick < 95)
            begin
                case ($urandom_range(0, 2))
                    0: cmd = fms_pkg::CMD_MOTOR_OFF;
                    1: cmd = fms_pkg::CMD_MOTOR_ON;
                    default: cmd = 8'($urandom);
                endcase
                request_queue.push_back(mk_req(fms_pkg::REQ_GROUND, any_level(), any_level(),
                                               any_level(), 1'($urandom), cmd));
            end
            else
                request_queue.push_back(mk_req(fms_pkg::REQ_UNUSED, any_level(), any_level(),
                                               any_level(), 1'($urandom), 8'($urandom)));
        end
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (request_queue.size() != 0 || req_valid || expected_outputs.size() != 0);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic write_brake_ticks(input logic [15:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        brake_limit = value;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // request driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                expected_outputs.push_back(apply_request(in_flight));
            if (!req_valid || !req_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (request_queue.size() > 0)
                begin
                    if (!quiet && $urandom_range(0, 9) == 0)
                    begin
                        send_gap = $urandom_range(0, 3);
                        req_valid <= 1'b0;
                    end
                    else
                    begin
                        in_flight = request_queue.pop_front();
                        req_valid <= 1'b1;
                        req_type <= in_flight.req_type;
                        aux2_level <= in_flight.aux2_level;
                        aux3_level <= in_flight.aux3_level;
                        aux4_level <= in_flight.aux4_level;
                        auto_enabled <= in_flight.auto_enabled;
                        out_cmd <= in_flight.out_cmd;
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_outputs.size() == 0)
                    report_mismatch("result with no request pending");
                else
                begin
                    want_rsp = expected_outputs.pop_front();
                    seen_rsp.alt_mode = alt_mode;
                    seen_rsp.nav_mode = nav_mode;
                    seen_rsp.sel.roll_pos = roll_pos_sel;
                    seen_rsp.sel.roll_rate = roll_rate_sel;
                    seen_rsp.sel.pitch_pos = pitch_pos_sel;
                    seen_rsp.sel.pitch_rate = pitch_rate_sel;
                    seen_rsp.motor_enable = motor_enable;
                    if ($isunknown({seen_rsp, yaw_sel}))
                        report_mismatch("unknown bits in result");
                    check_field("alt_mode", seen_rsp.alt_mode, want_rsp.alt_mode);
                    check_field("nav_mode", seen_rsp.nav_mode, want_rsp.nav_mode);
                    check_field("roll_pos_sel", seen_rsp.sel.roll_pos,
                                want_rsp.sel.roll_pos);
                    check_field("roll_rate_sel", seen_rsp.sel.roll_rate,
                                want_rsp.sel.roll_rate);
                    check_field("pitch_pos_sel", seen_rsp.sel.pitch_pos,
                                want_rsp.sel.pitch_pos);
                    check_field("pitch_rate_sel", seen_rsp.sel.pitch_rate,
                                want_rsp.sel.pitch_rate);
                    check_field("yaw_sel", yaw_sel, 0);
                    check_field("motor_enable", seen_rsp.motor_enable, want_rsp.motor_enable);
                end
            end
            if (quiet)
                rsp_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        queue_directed();
        settle();
        write_brake_ticks(16'd1);
        queue_random(350);
        settle();
        write_brake_ticks(16'd3);
        queue_random(350);
        settle();
        write_brake_ticks(16'd65535);
        queue_random(250);
        settle();
        write_brake_ticks(fms_pkg::BrakeTicksReset);
        queue_random(400);
        settle();
        write_brake_ticks(16'd2);
        quiet = 1'b1;
        queue_random(500);
        settle();
        if (mismatch_count == 0 && expected_outputs.size() == 0)
            $display("flight_mode_sequencer test passed");
        else
            $display("flight_mode_sequencer test failed");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("flight_mode_sequencer test failed");
        $finish;
    end

endmodule
